### rtl/wis_pkg.sv
// ----------------------------------------------------------------------------
// wis_pkg
// Shared types and constants of the weighted index sampler: table geometry,
// command codes and the sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wis_pkg;

    // Table geometry
    localparam int MAX_ENTRIES = 1024;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int WGT_W       = 64;

    // Command codes
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_TOTAL,
        S_FILL,
        S_CUR,
        S_PREV,
        S_ADD,
        S_ADD_LAST,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_RESP
    } state_t;

endpackage : wis_pkg

`default_nettype wire

### rtl/weighted_index_sampler_core.sv
// ----------------------------------------------------------------------------
// weighted_index_sampler_core
// Cumulative weight table in one synchronous RAM with a sequencer that
// updates entry weights and draws weighted samples by binary search.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time and returns one response for
// each. Every cycle the table RAM gives one registered read and one write.
// A weight update inside the table reads the old weight and then reads,
// adds the change to and writes back each entry from the updated index up
// to the top entry; an unchanged weight stops after the read. An update
// that grows the table reads the old total, unless the table was empty, and
// then writes one entry per cycle from just above the old top up to the
// index. Removing the top entry needs no RAM access. A sample of a
// non-empty table reads the total and then, for a non-zero total, takes
// ceil(log2(top+2)) search steps, each a RAM read and a compare. The longest
// transaction is an update of entry 0 of a full table. The response waits in
// an output register, so the next transaction is taken once that register is
// loaded. Entries above the top are always rewritten before they are read,
// so the RAM needs no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module weighted_index_sampler_core
    import wis_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // Request channel
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire logic             cmd,
    input  wire logic [IDX_W-1:0] entry_index,
    input  wire logic [WGT_W-1:0] new_weight,
    input  wire logic [WGT_W-1:0] roll,
    // Response channel
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output logic [IDX_W-1:0]      picked_index,
    output logic                  empty_res
);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    state_t             state_reg, state_next;

    logic               cmd_reg, cmd_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [WGT_W-1:0]   w_reg, w_next;
    logic [WGT_W-1:0]   roll_reg, roll_next;

    logic [IDX_W-1:0]   top_reg, top_next;
    logic               empty_reg, empty_next;

    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [WGT_W-1:0]   total_reg, total_next;
    logic [WGT_W-1:0]   cur_reg, cur_next;
    logic [WGT_W-1:0]   diff_reg, diff_next;
    logic [WGT_W-1:0]   target_reg, target_next;
    logic [IDX_W:0]     lo_reg, lo_next;
    logic [IDX_W:0]     hi_reg, hi_next;
    logic [IDX_W-1:0]   mid_reg, mid_next;
    logic [IDX_W-1:0]   pick_reg, pick_next;
    logic               emp_reg, emp_next;

    logic               add_vld_reg;
    logic [IDX_W-1:0]   waddr_reg;

    logic               rsp_valid_reg, rsp_valid_next;
    logic [IDX_W-1:0]   rsp_idx_reg, rsp_idx_next;
    logic               rsp_empty_reg, rsp_empty_next;

    logic [WGT_W-1:0]   mem [MAX_ENTRIES];
    logic [WGT_W-1:0]   mem_rd_reg;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [WGT_W-1:0]   mem_wdata;

    logic               req_acc;
    logic               slot_free;
    logic               is_remove;
    logic               is_grow;
    logic [IDX_W+1:0]   mid_sum;
    logic [WGT_W-1:0]   old_w;

    // ------------------------------------------------------------------
    // Handshake helpers
    // ------------------------------------------------------------------
    assign req_stall = (state_reg != S_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid    = rsp_valid_reg;
    assign picked_index = rsp_idx_reg;
    assign empty_res    = rsp_empty_reg;

    // Classify an incoming update
    assign is_remove = !empty_reg && (new_weight == '0) && (entry_index == top_reg);
    assign is_grow   = empty_reg || (entry_index > top_reg);

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign old_w   = cur_reg - mem_rd_reg;

    // ------------------------------------------------------------------
    // Table RAM: one write and one registered read per cycle
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rd_reg <= mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    if (cmd == CMD_SAMPLE)
                    begin
                        state_next = empty_reg ? S_RESP : S_TOTAL;
                    end
                    else if (is_remove)
                    begin
                        state_next = S_RESP;
                    end
                    else if (is_grow)
                    begin
                        state_next = empty_reg ? S_FILL : S_TOTAL;
                    end
                    else
                    begin
                        state_next = S_CUR;
                    end
                end
            end
            S_TOTAL:
            begin
                if (cmd_reg == CMD_SAMPLE)
                begin
                    state_next = (mem_rd_reg == '0) ? S_RESP : S_SRCH_RD;
                end
                else
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (ptr_reg == idx_reg)
                begin
                    state_next = S_RESP;
                end
            end
            S_CUR:
            begin
                if (idx_reg == '0)
                begin
                    state_next = (w_reg == mem_rd_reg) ? S_RESP
                               : ((idx_reg == top_reg) ? S_ADD_LAST : S_ADD);
                end
                else
                begin
                    state_next = S_PREV;
                end
            end
            S_PREV:
            begin
                state_next = (w_reg == old_w) ? S_RESP
                           : ((idx_reg == top_reg) ? S_ADD_LAST : S_ADD);
            end
            S_ADD:
            begin
                if (ptr_reg == top_reg)
                begin
                    state_next = S_ADD_LAST;
                end
            end
            S_ADD_LAST:
            begin
                // Stay here for the write-back when the top entry has only been read
                if (add_vld_reg)
                begin
                    state_next = S_RESP;
                end
            end
            S_SRCH_RD:
            begin
                state_next = (lo_reg < hi_reg) ? S_SRCH_CMP : S_RESP;
            end
            S_SRCH_CMP:
            begin
                state_next = S_SRCH_RD;
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and RAM control
    // ------------------------------------------------------------------
    always_comb
    begin
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        w_next         = w_reg;
        roll_next      = roll_reg;
        top_next       = top_reg;
        empty_next     = empty_reg;
        ptr_next       = ptr_reg;
        total_next     = total_reg;
        cur_next       = cur_reg;
        diff_next      = diff_reg;
        target_next    = target_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        pick_next      = pick_reg;
        emp_next       = emp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_idx_next   = rsp_idx_reg;
        rsp_empty_next = rsp_empty_reg;
        mem_re         = 1'b0;
        mem_raddr      = ptr_reg;
        mem_we         = 1'b0;
        mem_waddr      = ptr_reg;
        mem_wdata      = total_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    // Latch the transaction; default result is index 0, not empty
                    cmd_next  = cmd;
                    idx_next  = entry_index;
                    w_next    = new_weight;
                    roll_next = roll;
                    pick_next = '0;
                    emp_next  = 1'b0;
                    if (cmd == CMD_SAMPLE)
                    begin
                        emp_next  = empty_reg;
                        mem_re    = !empty_reg;
                        mem_raddr = top_reg;
                    end
                    else if (is_remove)
                    begin
                        // Drop the top entry
                        if (top_reg == '0)
                        begin
                            empty_next = 1'b1;
                        end
                        else
                        begin
                            top_next = top_reg - 1'b1;
                        end
                    end
                    else if (is_grow)
                    begin
                        if (empty_reg)
                        begin
                            total_next = '0;
                            ptr_next   = '0;
                        end
                        else
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = top_reg;
                        end
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = entry_index;
                    end
                end
            end
            S_TOTAL:
            begin
                if (cmd_reg == CMD_SAMPLE)
                begin
                    // Saturate the search target at the total
                    emp_next    = (mem_rd_reg == '0);
                    target_next = (roll_reg < mem_rd_reg) ? roll_reg + 1'b1 : mem_rd_reg;
                    lo_next     = '0;
                    hi_next     = {1'b0, top_reg} + 1'b1;
                end
                else
                begin
                    total_next = mem_rd_reg;
                    ptr_next   = top_reg + 1'b1;
                end
            end
            S_FILL:
            begin
                // New entries take the old total; the named one adds its weight
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = (ptr_reg == idx_reg) ? total_reg + w_reg : total_reg;
                if (ptr_reg == idx_reg)
                begin
                    top_next   = idx_reg;
                    empty_next = 1'b0;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_CUR:
            begin
                cur_next = mem_rd_reg;
                ptr_next = idx_reg;
                if (idx_reg == '0)
                begin
                    diff_next = w_reg - mem_rd_reg;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg - 1'b1;
                end
            end
            S_PREV:
            begin
                diff_next = w_reg - old_w;
            end
            S_ADD:
            begin
                // Issue the next read, write back the previous one
                mem_re    = 1'b1;
                mem_raddr = ptr_reg;
                mem_we    = add_vld_reg;
                mem_waddr = waddr_reg;
                mem_wdata = mem_rd_reg + diff_reg;
                if (ptr_reg != top_reg)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_ADD_LAST:
            begin
                // Drain the final write-back, or do the single entry at the top
                if (add_vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = waddr_reg;
                    mem_wdata = mem_rd_reg + diff_reg;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg;
                end
            end
            S_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next  = mid_sum[IDX_W:1];
                    mem_re    = 1'b1;
                    mem_raddr = mid_sum[IDX_W:1];
                end
                else
                begin
                    pick_next = (lo_reg > {1'b0, top_reg}) ? top_reg : lo_reg[IDX_W-1:0];
                end
            end
            S_SRCH_CMP:
            begin
                if (mem_rd_reg < target_reg)
                begin
                    lo_next = {1'b0, mid_reg} + 1'b1;
                end
                else
                begin
                    hi_next = {1'b0, mid_reg};
                end
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_idx_next   = pick_reg;
                    rsp_empty_next = emp_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Write-back tracking for the add sweep
    // ------------------------------------------------------------------
    logic add_issue;
    assign add_issue = (state_reg == S_ADD) || ((state_reg == S_ADD_LAST) && !add_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_vld_reg <= 1'b0;
        end
        else
        begin
            add_vld_reg <= add_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (add_issue)
        begin
            waddr_reg <= ptr_reg;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            top_reg       <= '0;
            empty_reg     <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            empty_reg     <= empty_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        idx_reg       <= idx_next;
        w_reg         <= w_next;
        roll_reg      <= roll_next;
        ptr_reg       <= ptr_next;
        total_reg     <= total_next;
        cur_reg       <= cur_next;
        diff_reg      <= diff_next;
        target_reg    <= target_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        pick_reg      <= pick_next;
        emp_reg       <= emp_next;
        rsp_idx_reg   <= rsp_idx_next;
        rsp_empty_reg <= rsp_empty_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A RAM read and write in one cycle never hit the same entry
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("RAM read and write collide on one entry");

    // The fill sweep never runs past the named entry
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> (ptr_reg <= idx_reg))
        else $error("fill pointer beyond entry index");

    // Finishing a fill leaves a non-empty table topped at the named entry
    a_fill_top: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FILL) && (ptr_reg == idx_reg))
        |=> (!empty_reg && (top_reg == $past(idx_reg))))
        else $error("fill did not set the top entry");

    // The search window stays inside the table
    a_srch_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH_RD) |-> ((lo_reg <= hi_reg) && (hi_reg <= {1'b0, top_reg} + 1'b1)))
        else $error("search window out of range");

    // The add sweep only covers entries up to the top
    a_add_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD) |-> (ptr_reg <= top_reg))
        else $error("add sweep beyond top entry");

endmodule : weighted_index_sampler_core

`default_nettype wire
